// ----- rtl/core/pwg_pkg.sv -----
`timescale 1ns / 1ps
// shared types, register codes and constants of the periodic waveform generator
package pwg_pkg;

	// default sizes
	localparam int PHASE_BITS_DEF  = 16;
	localparam int SINE_DEPTH_DEF  = 256;

	// configuration register indexes
	localparam logic [1:0] REG_WAVE_MODE    = 2'd0;
	localparam logic [1:0] REG_PERIOD_SCALE = 2'd1;
	localparam logic [1:0] REG_MIN_LEVEL    = 2'd2;
	localparam logic [1:0] REG_MAX_LEVEL    = 2'd3;

	// wave mode codes
	localparam logic [1:0] MODE_SINE     = 2'd0;
	localparam logic [1:0] MODE_TRIANGLE = 2'd1;
	localparam logic [1:0] MODE_SQUARE   = 2'd2;

	// register reset values
	localparam logic [1:0]         WAVE_MODE_RST    = MODE_SINE;
	localparam logic [23:0]        PERIOD_SCALE_RST = 24'h010000;
	localparam logic signed [15:0] MIN_LEVEL_RST    = 16'sd0;
	localparam logic signed [15:0] MAX_LEVEL_RST    = 16'sd32767;

	// q30 constants for the quarter-wave table
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam longint      ONE_Q30     = 64'sd1073741824;
	localparam longint      HALF_Q30    = 64'sd536870912;
	localparam longint      WAVE_MAX    = 64'sd32767;

	// q1.15 wave extremes
	localparam logic signed [15:0] WAVE_POS_ONE = 16'sh7fff;
	localparam logic signed [15:0] WAVE_NEG_ONE = 16'sh8000;

	// wave sample as it leaves the table stage
	typedef struct packed {
		logic               use_sine;
		logic               neg;
		logic [14:0]        sine_mag;
		logic signed [15:0] alt;
	} wave_t;

endpackage

// ----- rtl/core/pwg_phase.sv -----
`timescale 1ns / 1ps
// phase stage: time times period scale, fractional part kept
module pwg_phase import pwg_pkg::*; #(
	parameter int PHASE_BITS = PHASE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [31:0]           time_value,
	input  logic [23:0]           period_scale,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PHASE_BITS-1:0] phase
);

	logic                  v_s1;
	logic [PHASE_BITS-1:0] phase_s1;
	logic                  adv_s1;
	logic [31:0]           prod;

	assign adv_s1   = !v_s1 || !out_stall;
	assign in_stall = !adv_s1;

	// only the low 32 product bits reach the phase
	assign prod = time_value * 32'(period_scale);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			phase_s1 <= prod[31 -: PHASE_BITS];
		end
	end

	assign out_valid = v_s1;
	assign phase     = phase_s1;

endmodule

// ----- rtl/core/pwg_wave.sv -----
`timescale 1ns / 1ps
// wave stages: table index, triangle and square, quarter-wave sine table read
module pwg_wave import pwg_pkg::*; #(
	parameter int PHASE_BITS       = PHASE_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [1:0]            wave_mode,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PHASE_BITS-1:0] phase,
	output logic                  out_valid,
	input  logic                  out_stall,
	output wave_t                 wave
);

	localparam int RW   = PHASE_BITS - 2;
	localparam int IDXW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PW   = RW + 1 + IDXW;
	localparam int TW   = RW + 15;
	localparam logic [RW:0] QUARTER = (RW + 1)'(1) << RW;

	// quarter-wave table, built at elaboration with a q30 series
	logic [14:0] sine_rom [SINE_TABLE_DEPTH + 1];

	for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam logic [63:0] X  = HALF_PI_Q30 * 64'(k) / SINE_TABLE_DEPTH;
		localparam logic [63:0] X2 = (X * X) >> 30;
		localparam logic [63:0] T1 = ((X  * X2) >> 30) / 6;
		localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 20;
		localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 42;
		localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 72;
		localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 110;
		localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 156;
		localparam logic [63:0] T7 = ((T6 * X2) >> 30) / 210;
		localparam longint S  = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
			+ longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7);
		localparam longint SC = (S < 0) ? 64'sd0 : ((S > ONE_Q30) ? ONE_Q30 : S);
		localparam longint E  = (SC * WAVE_MAX + HALF_Q30) >>> 30;
		localparam longint EC = (E > WAVE_MAX) ? WAVE_MAX : E;
		assign sine_rom[k] = 15'(EC);
	end

	logic              v_s2, v_s3;
	logic              adv_s2, adv_s3;
	logic [IDXW-1:0]   idx_s2;
	logic              neg_s2, sine_s2;
	logic signed [15:0] alt_s2;
	wave_t             wave_s3;

	logic [1:0]        quad;
	logic [RW-1:0]     r;
	logic [RW:0]       pos;
	logic [PW-1:0]     idx_prod;
	logic [TW-1:0]     tri_full;
	logic [14:0]       tri_v;
	logic signed [16:0] tri_w;
	logic signed [15:0] tri_sat;
	logic signed [15:0] alt;

	assign adv_s3   = !v_s3 || !out_stall;
	assign adv_s2   = !v_s2 || adv_s3;
	assign in_stall = !adv_s2;

	assign quad = phase[PHASE_BITS-1 -: 2];
	assign r    = phase[RW-1:0];

	// mirror in the second and fourth quadrants
	assign pos      = quad[0] ? (QUARTER - (RW + 1)'(r)) : (RW + 1)'(r);
	assign idx_prod = PW'(pos) * PW'(SINE_TABLE_DEPTH);

	// triangle ramp v = r * 32768 >> (PHASE_BITS - 2)
	assign tri_full = {r, 15'b0};
	assign tri_v    = 15'(tri_full >> RW);

	always_comb begin
		case (quad)
			2'd0:    tri_w = 17'sd0 + 17'($unsigned(tri_v));
			2'd1:    tri_w = 17'sd32768 - 17'($unsigned(tri_v));
			2'd2:    tri_w = 17'sd0 - 17'($unsigned(tri_v));
			default: tri_w = 17'($unsigned(tri_v)) - 17'sd32768;
		endcase
		// full scale +1 clips to the largest q1.15 value
		tri_sat = (tri_w > 17'sd32767) ? WAVE_POS_ONE : 16'(tri_w);
	end

	always_comb begin
		case (wave_mode)
			MODE_TRIANGLE: alt = tri_sat;
			// positive only strictly inside the first half period
			MODE_SQUARE:   alt = ((phase != '0) && !quad[1]) ? WAVE_POS_ONE : WAVE_NEG_ONE;
			default:       alt = 16'sd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s2) begin
				v_s2 <= in_valid;
			end
			if (adv_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && in_valid) begin
			idx_s2  <= idx_prod[RW +: IDXW];
			neg_s2  <= quad[1];
			sine_s2 <= (wave_mode == MODE_SINE);
			alt_s2  <= alt;
		end
		if (adv_s3 && v_s2) begin
			wave_s3.sine_mag <= sine_rom[idx_s2];
			wave_s3.neg      <= neg_s2;
			wave_s3.use_sine <= sine_s2;
			wave_s3.alt      <= alt_s2;
		end
	end

	assign out_valid = v_s3;
	assign wave      = wave_s3;

endmodule

// ----- rtl/core/pwg_scale.sv -----
`timescale 1ns / 1ps
// scale stages: map wave from [-1,1] onto min..max with rounding
module pwg_scale import pwg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] min_level,
	input  logic signed [15:0] max_level,
	input  logic               in_valid,
	output logic               in_stall,
	input  wave_t              wave,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] level_out
);

	logic               v_s4, v_s5, v_s6;
	logic               adv_s4, adv_s5, adv_s6;
	logic [31:0]        prod_s4;
	logic [15:0]        q_s5;
	logic signed [15:0] level_s6;

	logic [15:0]        mag_q;
	logic               span_neg_q;
	logic signed [16:0] span;

	logic signed [15:0] wave_val;
	logic [15:0]        u;
	logic [31:0]        num;
	logic [15:0]        q0;
	logic [16:0]        r0;
	logic [15:0]        q;
	logic [15:0]        q_signed;

	assign adv_s6   = !v_s6 || !out_stall;
	assign adv_s5   = !v_s5 || adv_s6;
	assign adv_s4   = !v_s4 || adv_s5;
	assign in_stall = !adv_s4;

	// span magnitude; steady only if the user holds min and max
	assign span = 17'(max_level) - 17'(min_level);

	always_ff @(posedge clk) begin
		span_neg_q <= span[16];
		mag_q      <= span[16] ? 16'(-span) : 16'(span);
	end

	always_comb begin
		if (wave.use_sine) begin
			wave_val = wave.neg ? -$signed({1'b0, wave.sine_mag}) : $signed({1'b0, wave.sine_mag});
		end else begin
			wave_val = wave.alt;
		end
		u = $unsigned(wave_val) ^ 16'h8000;
	end

	// divide by 65535: quotient estimate from the high half, one correction
	assign num = prod_s4 + 32'd32767;
	assign q0  = num[31:16];
	assign r0  = {1'b0, num[15:0]} + {1'b0, q0};
	assign q   = q0 + ((r0 >= 17'd65535) ? 16'd1 : 16'd0);

	assign q_signed = span_neg_q ? (~q_s5 + 16'd1) : q_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv_s4) begin
				v_s4 <= in_valid;
			end
			if (adv_s5) begin
				v_s5 <= v_s4;
			end
			if (adv_s6) begin
				v_s6 <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && in_valid) begin
			prod_s4 <= 32'(mag_q) * 32'(u);
		end
		if (adv_s5 && v_s4) begin
			q_s5 <= q;
		end
		if (adv_s6 && v_s5) begin
			level_s6 <= $signed($unsigned(min_level) + q_signed);
		end
	end

	assign out_valid = v_s6;
	assign level_out = level_s6;

endmodule

// ----- rtl/core/periodic_waveform_generator_core.sv -----
`timescale 1ns / 1ps
// top level of the periodic waveform generator
// Turns each time_value (unsigned q16.16) into one level_out sample. The
// phase is the fractional part of time_value * period_scale, kept to
// PHASE_BITS bits; the wave is a quarter-wave table sine, a four-segment
// triangle or a square (high only strictly inside the first half period),
// in q1.15, then mapped so that -1 gives min_level and +1 gives max_level
// with rounding; a reversed span is fine. The datapath is a six-stage
// pipeline (phase multiply, table index, table read, level multiply,
// divide by 65535, final add): one transaction enters every cycle while
// in_stall is low. Each stage takes new data whenever it is empty or its
// successor moves, so bubbles close up and input is taken while a finished
// sample waits at a stalled output, as long as some stage is empty.
// Registers are written through cfg_write/cfg_index/cfg_data and must only
// change while the pipeline is empty.
module periodic_waveform_generator_core import pwg_pkg::*; #(
	parameter int PHASE_BITS       = PHASE_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	// sample time in
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        time_value,
	// level out
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] level_out
);

	// configuration registers
	logic [1:0]         wave_mode_q;
	logic [23:0]        period_scale_q;
	logic signed [15:0] min_level_q;
	logic signed [15:0] max_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_mode_q    <= WAVE_MODE_RST;
			period_scale_q <= PERIOD_SCALE_RST;
			min_level_q    <= MIN_LEVEL_RST;
			max_level_q    <= MAX_LEVEL_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_WAVE_MODE:    wave_mode_q    <= cfg_data[1:0];
				REG_PERIOD_SCALE: period_scale_q <= cfg_data;
				REG_MIN_LEVEL:    min_level_q    <= $signed(cfg_data[15:0]);
				REG_MAX_LEVEL:    max_level_q    <= $signed(cfg_data[15:0]);
				default: ;
			endcase
		end
	end

	// phase stage to wave stages
	logic                  ph_valid;
	logic                  ph_stall;
	logic [PHASE_BITS-1:0] ph_phase;

	// wave stages to scale stages
	logic  wv_valid;
	logic  wv_stall;
	wave_t wv_wave;

	// stage 1: phase from time times period
	pwg_phase #(
		.PHASE_BITS (PHASE_BITS)
	) u_phase (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.time_value   (time_value),
		.period_scale (period_scale_q),
		.out_valid    (ph_valid),
		.out_stall    (ph_stall),
		.phase        (ph_phase)
	);

	// stages 2 and 3: table index, triangle, square, table read
	pwg_wave #(
		.PHASE_BITS       (PHASE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_wave (
		.clk       (clk),
		.arst_n    (arst_n),
		.wave_mode (wave_mode_q),
		.in_valid  (ph_valid),
		.in_stall  (ph_stall),
		.phase     (ph_phase),
		.out_valid (wv_valid),
		.out_stall (wv_stall),
		.wave      (wv_wave)
	);

	// stages 4 to 6: linear map onto min..max, output register
	pwg_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.min_level (min_level_q),
		.max_level (max_level_q),
		.in_valid  (wv_valid),
		.in_stall  (wv_stall),
		.wave      (wv_wave),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.level_out (level_out)
	);

	// input only backs up when every stage holds a transaction
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && ph_valid && wv_valid))
		else $error("input stalled while the pipeline has a bubble");

	// an accepted transaction lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> ph_valid)
		else $error("accepted transaction missing from phase stage");

	// the scale stages back up only behind a stalled full output
	a_scale_stall: assert property (@(posedge clk) disable iff (!arst_n)
		wv_stall |-> (out_valid && out_stall))
		else $error("scale stages stalled without output back-pressure");

endmodule
